// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file pvm_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked check that also runs through reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- src/pvm_pkg.sv -----
// Shared widths, types and rounding helpers for the pose to view matrix unit.
// No dependencies.
package pvm_pkg;

    localparam int QUAT_W  = 16;
    localparam int POS_W   = 32;
    localparam int ROT_W   = 16;
    localparam int QPROD_W = 2 * QUAT_W;       // raw quaternion product
    localparam int QSUM_W  = QPROD_W + 3;      // doubled sum, Q.28
    localparam int MPROD_W = ROT_W + POS_W;    // rotation entry times coordinate
    localparam int TSUM_W  = MPROD_W + 3;      // negated dot product, Q.30
    localparam int FRAC_SH = 14;

    localparam int IN_W  = 4 * QUAT_W + 3 * POS_W;
    localparam int OUT_W = 9 * ROT_W + 3 * POS_W;

    localparam logic signed [QSUM_W-1:0] ONE_Q28 = QSUM_W'(1) <<< 28;
    localparam logic signed [ROT_W-1:0]  ROT_MAX = ROT_W'(16384);
    localparam logic signed [ROT_W-1:0]  ROT_MIN = -ROT_W'(16384);

    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [ROT_W-1:0]   t_rot;
    typedef logic signed [QPROD_W-1:0] t_qprod;
    typedef logic signed [QSUM_W-1:0]  t_qsum;
    typedef logic signed [MPROD_W-1:0] t_mprod;
    typedef logic signed [TSUM_W-1:0]  t_tsum;

    // Q.28 to Q1.14, nearest with ties upward, clamped to plus or minus one
    function automatic t_rot rot_round(input t_qsum q28);
        logic signed [QSUM_W-1:0]         biased;
        logic signed [QSUM_W-FRAC_SH-1:0] shifted;
        biased  = q28 + (QSUM_W'(1) <<< (FRAC_SH - 1));
        shifted = biased[QSUM_W-1:FRAC_SH];
        if (shifted > (QSUM_W-FRAC_SH)'(ROT_MAX)) begin
            return ROT_MAX;
        end else if (shifted < (QSUM_W-FRAC_SH)'(ROT_MIN)) begin
            return ROT_MIN;
        end
        return shifted[ROT_W-1:0];
    endfunction

    // Q.30 to Q16.16, nearest with ties upward, saturated to 32 bits
    function automatic t_pos trans_round(input t_tsum q30);
        logic signed [TSUM_W-1:0]         biased;
        logic signed [TSUM_W-FRAC_SH-1:0] shifted;
        logic signed [TSUM_W-FRAC_SH-1:0] lim_hi;
        logic signed [TSUM_W-FRAC_SH-1:0] lim_lo;
        biased  = q30 + (TSUM_W'(1) <<< (FRAC_SH - 1));
        shifted = biased[TSUM_W-1:FRAC_SH];
        lim_hi  = (TSUM_W-FRAC_SH)'({1'b0, {(POS_W-1){1'b1}}});
        lim_lo  = -lim_hi - (TSUM_W-FRAC_SH)'(1);
        if (shifted > lim_hi) begin
            return lim_hi[POS_W-1:0];
        end else if (shifted < lim_lo) begin
            return lim_lo[POS_W-1:0];
        end
        return shifted[POS_W-1:0];
    endfunction

endpackage

// ----- src/pose_to_view_matrix_unit.sv -----
// Pose to view matrix unit: quaternion and camera position in, view rotation
// and translation out. Depends on pvm_pkg.
//
//  channel   dir  data bits  fields, lowest bit up
//  s_axis    in   160        quat_x quat_y quat_z quat_w cam_x cam_y cam_z
//  m_axis    out  240        v00 v01 v02 v10 v11 v12 v20 v21 v22
//                            trans_x trans_y trans_z
//
// Four register stages: quaternion products, rotation sums with rounding,
// entry-by-coordinate products, dot products with rounding into the output
// register. One request per cycle is sustained while the output is not stalled.
// A stage advances when it is empty or the one after it moves, so bubbles close up
// and a stalled output holds without losing or repeating a request.
// i_rst_n clears the valid bits only.
module pose_to_view_matrix_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, cam_x, cam_y, cam_z
    input  logic [pvm_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // v00, v01, v02, v10, v11, v12, v20, v21, v22, trans_x, trans_y, trans_z
    output logic [pvm_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    localparam int QW = pvm_pkg::QUAT_W;
    localparam int PW = pvm_pkg::POS_W;
    localparam int RW = pvm_pkg::ROT_W;
    localparam int SW = pvm_pkg::QSUM_W;
    localparam int TW = pvm_pkg::TSUM_W;

    logic r_s1_vld, r_s2_vld, r_s3_vld, r_o_vld;
    logic en1, en2, en3, en_out;

    // stage 1: raw quaternion products
    pvm_pkg::t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    pvm_pkg::t_pos   r_s1_cam [3];
    // stage 2: rotation entries, row-major view order
    pvm_pkg::t_rot   r_v [9];
    pvm_pkg::t_pos   r_s2_cam [3];
    // stage 3: entry times coordinate
    pvm_pkg::t_rot   r_s3_v [9];
    pvm_pkg::t_mprod r_m [9];
    // output register
    pvm_pkg::t_rot   r_o_v [9];
    pvm_pkg::t_pos   r_o_t [3];

    pvm_pkg::t_quat  qx, qy, qz, qw;
    pvm_pkg::t_qsum  exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
    pvm_pkg::t_qsum  n_sum [9];
    pvm_pkg::t_tsum  n_dot [3];

    assign en_out = !r_o_vld || i_m_axis_tready;
    assign en3    = !r_s3_vld || en_out;
    assign en2    = !r_s2_vld || en3;
    assign en1    = !r_s1_vld || en2;

    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r_o_vld;

    assign qx = i_s_axis_tdata[0*QW +: QW];
    assign qy = i_s_axis_tdata[1*QW +: QW];
    assign qz = i_s_axis_tdata[2*QW +: QW];
    assign qw = i_s_axis_tdata[3*QW +: QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_vld <= i_s_axis_tvalid;
            end
            if (en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (en_out) begin
                r_o_vld <= r_s3_vld;
            end
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_xx <= qx * qx;
            r_yy <= qy * qy;
            r_zz <= qz * qz;
            r_xy <= qx * qy;
            r_xz <= qx * qz;
            r_yz <= qy * qz;
            r_wx <= qw * qx;
            r_wy <= qw * qy;
            r_wz <= qw * qz;
            for (int i = 0; i < 3; i++) begin
                r_s1_cam[i] <= i_s_axis_tdata[4*QW + i*PW +: PW];
            end
        end
    end

    // stage 2: doubled sums in Q.28
    always_comb begin
        exx = SW'(r_xx);
        eyy = SW'(r_yy);
        ezz = SW'(r_zz);
        exy = SW'(r_xy);
        exz = SW'(r_xz);
        eyz = SW'(r_yz);
        ewx = SW'(r_wx);
        ewy = SW'(r_wy);
        ewz = SW'(r_wz);
        n_sum[0] = pvm_pkg::ONE_Q28 - ((eyy + ezz) <<< 1);
        n_sum[1] = (exy + ewz) <<< 1;
        n_sum[2] = (exz - ewy) <<< 1;
        n_sum[3] = (exy - ewz) <<< 1;
        n_sum[4] = pvm_pkg::ONE_Q28 - ((exx + ezz) <<< 1);
        n_sum[5] = (eyz + ewx) <<< 1;
        n_sum[6] = (exz + ewy) <<< 1;
        n_sum[7] = (eyz - ewx) <<< 1;
        n_sum[8] = pvm_pkg::ONE_Q28 - ((exx + eyy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int i = 0; i < 9; i++) begin
                r_v[i] <= pvm_pkg::rot_round(n_sum[i]);
            end
            r_s2_cam <= r_s1_cam;
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= pvm_pkg::MPROD_W'(r_v[i]) * pvm_pkg::MPROD_W'(r_s2_cam[i % 3]);
            end
            r_s3_v <= r_v;
        end
    end

    // stage 4: negated dot products, Q.30
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_dot[r] = -(TW'(r_m[3*r]) + TW'(r_m[3*r+1]) + TW'(r_m[3*r+2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_v <= r_s3_v;
            for (int r = 0; r < 3; r++) begin
                r_o_t[r] <= pvm_pkg::trans_round(n_dot[r]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            o_m_axis_tdata[i*RW +: RW] = r_o_v[i];
        end
        for (int r = 0; r < 3; r++) begin
            o_m_axis_tdata[9*RW + r*PW +: PW] = r_o_t[r];
        end
    end

endmodule

// ----- src/pvm_checker.sv -----
// Port-level checks for pose_to_view_matrix_unit, attached by bind.
// Depends on pvm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pvm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [pvm_pkg::IN_W-1:0]  i_s_axis_tdata,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [pvm_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int RW = pvm_pkg::ROT_W;

    logic          in_acc, out_acc, rot_ok, data_seen;
    logic [2:0]    r_cnt;
    pvm_pkg::t_rot ent;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign data_seen = ^i_s_axis_tdata || !(^i_s_axis_tdata);

    // requests in flight: four stages hold at most four
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(in_acc) - 3'(out_acc);
        end
    end

    always_comb begin
        rot_ok = 1'b1;
        ent    = '0;
        for (int i = 0; i < 9; i++) begin
            ent = o_m_axis_tdata[i*RW +: RW];
            if (ent > pvm_pkg::ROT_MAX || ent < pvm_pkg::ROT_MIN) begin
                rot_ok = 1'b0;
            end
        end
    end

    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    `ASSERT_CHK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
    `ASSERT_CHK(a_no_invent, i_clk, i_rst_n, o_m_axis_tvalid |-> r_cnt != 3'd0 && data_seen)
    `ASSERT_CHK(a_depth, i_clk, i_rst_n, r_cnt <= 3'd4)
    `ASSERT_CHK(a_rot_range, i_clk, i_rst_n, o_m_axis_tvalid |-> rot_ok)

endmodule

bind pose_to_view_matrix_unit pvm_checker u_pvm_checker (.*);

// ----- sim/pose_to_view_matrix_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for pose_to_view_matrix_unit: streams poses in, predicts each view
// rotation and translation, and checks every result in order. Depends on pvm_pkg.
module pose_to_view_matrix_unit_tb;

    // Packed so that quat_x sits in the lowest bits, matching the tdata layout
    typedef struct packed {
        pvm_pkg::t_pos  cz;
        pvm_pkg::t_pos  cy;
        pvm_pkg::t_pos  cx;
        pvm_pkg::t_quat qw;
        pvm_pkg::t_quat qz;
        pvm_pkg::t_quat qy;
        pvm_pkg::t_quat qx;
    } t_pose;

    localparam int     IN_W           = pvm_pkg::IN_W;
    localparam int     OUT_W          = pvm_pkg::OUT_W;
    localparam int     ROT_W          = pvm_pkg::ROT_W;
    localparam int     POS_W          = pvm_pkg::POS_W;
    localparam longint Q28_ONE        = longint'(pvm_pkg::ONE_Q28);
    localparam longint ROT_HI         = longint'(pvm_pkg::ROT_MAX);
    localparam longint ROT_LO         = longint'(pvm_pkg::ROT_MIN);
    localparam longint POS_HI         = 64'sd2147483647;
    localparam longint POS_LO         = -64'sd2147483648;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     LONG_HOLD      = 300;
    localparam int     DRAIN_CYCLES   = 16;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // quat_x, quat_y, quat_z, quat_w, cam_x, cam_y, cam_z
    logic [IN_W-1:0]   i_s_axis_tdata  = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // v00, v01, v02, v10, v11, v12, v20, v21, v22, trans_x, trans_y, trans_z
    logic [OUT_W-1:0]  o_m_axis_tdata;

    logic [OUT_W-1:0]  expected_views [$];
    int                mismatch_cnt = 0;
    int                idle_cycles  = 0;
    int                rx_stall     = 0;
    int                rx_hold_req  = 0;
    bit                gaps_on      = 1'b1;

    pose_to_view_matrix_unit dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic longint q14_round(input longint v);
        return (v + 64'sd8192) >>> pvm_pkg::FRAC_SH;
    endfunction

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // V = R transposed, then T = -V * position
    function automatic logic [OUT_W-1:0] predict_view(input t_pose p);
        longint x, y, z, w;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rot [9];
        longint cam [3];
        longint dot;
        logic [OUT_W-1:0] v;
        int r;
        x = p.qx;
        y = p.qy;
        z = p.qz;
        w = p.qw;
        cam[0] = p.cx;
        cam[1] = p.cy;
        cam[2] = p.cz;
        xx = 2 * x * x;
        yy = 2 * y * y;
        zz = 2 * z * z;
        xy = 2 * x * y;
        xz = 2 * x * z;
        yz = 2 * y * z;
        wx = 2 * w * x;
        wy = 2 * w * y;
        wz = 2 * w * z;
        rot[0] = Q28_ONE - (yy + zz);
        rot[1] = xy + wz;
        rot[2] = xz - wy;
        rot[3] = xy - wz;
        rot[4] = Q28_ONE - (xx + zz);
        rot[5] = yz + wx;
        rot[6] = xz + wy;
        rot[7] = yz - wx;
        rot[8] = Q28_ONE - (xx + yy);
        for (r = 0; r < 9; r++) begin
            rot[r] = sat(q14_round(rot[r]), ROT_LO, ROT_HI);
            v[r*ROT_W +: ROT_W] = ROT_W'(rot[r]);
        end
        for (r = 0; r < 3; r++) begin
            dot = rot[3*r] * cam[0] + rot[3*r+1] * cam[1] + rot[3*r+2] * cam[2];
            v[9*ROT_W + r*POS_W +: POS_W] = POS_W'(sat(q14_round(-dot), POS_LO, POS_HI));
        end
        return v;
    endfunction

    function automatic t_pose mk_pose(input int qx, qy, qz, qw, input int cx, cy, cz);
        t_pose p;
        p.qx = pvm_pkg::t_quat'(qx);
        p.qy = pvm_pkg::t_quat'(qy);
        p.qz = pvm_pkg::t_quat'(qz);
        p.qw = pvm_pkg::t_quat'(qw);
        p.cx = pvm_pkg::t_pos'(cx);
        p.cy = pvm_pkg::t_pos'(cy);
        p.cz = pvm_pkg::t_pos'(cz);
        return p;
    endfunction

    // Mostly unit quaternions, some unnormalised, a few with any bit pattern
    function automatic t_pose rand_pose();
        int  q [4];
        int  c [3];
        int  i;
        int  mode;
        real norm;
        mode = $urandom_range(9);
        for (i = 0; i < 4; i++) begin
            q[i] = (mode == 9) ? int'($urandom_range(65535))
                               : int'($urandom_range(32768)) - 16384;
        end
        if (mode < 6) begin
            norm = $sqrt(real'(q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3]));
            if (norm < 1.0) begin
                q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 16384;
            end else begin
                for (i = 0; i < 4; i++) q[i] = int'(q[i] * 16384.0 / norm);
            end
        end
        for (i = 0; i < 3; i++) begin
            case ($urandom_range(7))
                0, 1, 2: c[i] = $urandom();
                3, 4:    c[i] = int'($urandom_range(2097152)) - 1048576;
                5:       c[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: c[i] = int'($urandom_range(65535)) - 32768;
            endcase
        end
        return mk_pose(q[0], q[1], q[2], q[3], c[0], c[1], c[2]);
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(99) < 88) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    endfunction

    task automatic send_pose(input t_pose p);
        int gap;
        gap = (gaps_on && $urandom_range(1)) ? idle_len() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_views.push_back(predict_view(p));
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_views.size() != 0);
    endtask

    task automatic check_view(input logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        longint e, a;
        string  name;
        int     f;
        if (expected_views.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_cnt++;
            return;
        end
        want = expected_views.pop_front();
        for (f = 0; f < 12; f++) begin
            if (f < 9) begin
                name = $sformatf("v%0d%0d", f / 3, f % 3);
                e = longint'($signed(want[f*ROT_W +: ROT_W]));
                a = longint'($signed(got[f*ROT_W +: ROT_W]));
            end else begin
                name = $sformatf("trans_%c", 8'd120 + 8'(f - 9));
                e = longint'($signed(want[9*ROT_W + (f-9)*POS_W +: POS_W]));
                a = longint'($signed(got[9*ROT_W + (f-9)*POS_W +: POS_W]));
            end
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                mismatch_cnt++;
            end
        end
    endtask

    // Result side: check, then pick next ready; long holds come from the tests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_view(o_m_axis_tdata);
            if (rx_hold_req > 0) begin
                rx_stall    = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(99) < 20) begin
                rx_stall = idle_len() - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed_poses();
        gaps_on = 1'b0;
        send_pose(mk_pose(0, 0, 0, 16384, 0, 0, 0));
        send_pose(mk_pose(0, 0, 0, 16384, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000));
        send_pose(mk_pose(0, 0, 0, 16384, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_pose(mk_pose(0, 0, 0, 0, 1, -1, 32'h1234_5678));
        send_pose(mk_pose(16384, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000));
        send_pose(mk_pose(0, 16384, 0, 0, 32'h10000, 32'h20000, 32'h30000));
        send_pose(mk_pose(0, 0, 16384, 0, 32'h10000, 32'h20000, 32'h30000));
        send_pose(mk_pose(0, 0, 0, -16384, -5, 7, 32'h7FFF_FFFF));
        send_pose(mk_pose(11585, 0, 0, 11585, 32'h50000, -32'h30000, 32'h8000));
        send_pose(mk_pose(0, 11585, 0, 11585, 32'h50000, -32'h30000, 32'h8000));
        send_pose(mk_pose(0, 0, 11585, 11585, 32'h50000, -32'h30000, 32'h8000));
        send_pose(mk_pose(8192, 8192, 8192, 8192, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // not of unit length: entries leave [-1, 1] and saturate
        send_pose(mk_pose(16384, 16384, 16384, 16384, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_pose(mk_pose(-16384, -16384, -16384, -16384, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        // mostly components past plus or minus one in Q1.14, taken at face value
        send_pose(mk_pose(-32768, -32768, -32768, -32768, 32'h1_0000, 32'h1_0000, 32'h1_0000));
        send_pose(mk_pose(32767, -32768, 32767, -32768, 32'h7FFF_FFFF, 0, 32'h8000_0000));
        send_pose(mk_pose(-32768, 0, 0, 32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pose(mk_pose(0, 0, 0, 16384, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pose(mk_pose(32767, 32767, 32767, 32767, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // exact halves: rotation and translation ties round upward
        send_pose(mk_pose(64, 64, 0, 0, 0, 8192, 0));
        send_pose(mk_pose(64, 64, 0, 0, 0, -8192, 0));
        send_pose(mk_pose(64, -64, 0, 0, 0, 8192, 0));
        wait_for_results();
    endtask

    task automatic test_random_poses();
        int blk, n;
        for (blk = 0; blk < 10; blk++) begin
            gaps_on = ($urandom_range(3) != 0);
            for (n = 0; n < 100; n++) send_pose(rand_pose());
        end
        gaps_on = 1'b1;
    endtask

    // Output held off while requests keep coming, so the pipe fills and stalls
    task automatic test_output_backpressure();
        int n;
        gaps_on     = 1'b0;
        rx_hold_req = LONG_HOLD;
        for (n = 0; n < 40; n++) send_pose(rand_pose());
        gaps_on = 1'b1;
        wait_for_results();
    endtask

    task automatic test_drained_bursts();
        int b, n;
        gaps_on = 1'b1;
        for (b = 0; b < 4; b++) begin
            for (n = 0; n < 20; n++) send_pose(rand_pose());
            wait_for_results();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_poses();
        test_random_poses();
        test_output_backpressure();
        test_drained_bursts();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_views.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_views.size());
        end
        if (mismatch_cnt == 0 && expected_views.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
